/* design/bws_pkg.sv */
// Shared types, sizes and codes for the scrolling bitmap window scanout.
// Used by every module of the block; depends on nothing.
package bws_pkg;

    // Geometry of the screen window and of the pixel store.
    localparam int SCREEN_COLS = 32;
    localparam int SCREEN_ROWS = 4;
    localparam int BUFFER_COLS = 320;

    // Field widths of a request.
    localparam int KIND_W = 2;
    localparam int COL_W  = 9;
    localparam int ROW_W  = 2;

    localparam int STORE_DEPTH = SCREEN_ROWS * BUFFER_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DOT_CNT_W   = (SCREEN_COLS > 1) ? $clog2(SCREEN_COLS) : 1;
    localparam int BCOL_W      = $clog2(BUFFER_COLS);
    localparam int WALK_W      = (COL_W > BCOL_W) ? COL_W : BCOL_W;

    // Request codes.
    typedef enum logic [KIND_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_SCAN   = 2'd1,
        REQ_VIEW   = 2'd2,
        REQ_SCROLL = 2'd3
    } req_kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRAP,
        ST_SCAN
    } ctrl_state_t;

    // Access to the bitmap memory: one write and one read port.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // Tag that travels alongside a memory read toward the output queue.
    typedef struct packed {
        logic issue;
        logic blank;
        logic last;
    } read_tag_t;

endpackage

/* design/bws_bitmap_ram.sv */
// One-bit-wide synchronous pixel store with one write and one read port.
// Depends on bws_pkg for its depth and the request struct.
module bws_bitmap_ram (
    input  logic              clk,
    input  bws_pkg::mem_req_t req,
    output logic              rdata
);
    import bws_pkg::*;

    logic mem_reg [STORE_DEPTH];
    logic rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
    end

    // Read port with registered data.
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem_reg[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/bws_ctrl.sv */
// Request sequencer: clearing pass, pixel writes, view offset and row scan reads.
// Depends on bws_pkg for codes, states and the memory request struct.
module bws_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bws_pkg::KIND_W-1:0] req_type,
    input  logic [bws_pkg::COL_W-1:0]  pixel_col,
    input  logic [bws_pkg::ROW_W-1:0]  pixel_row,
    input  logic                       pixel_on,
    input  logic [bws_pkg::COL_W-1:0]  view_start,
    input  logic [bws_pkg::COL_W-1:0]  scroll_limit,
    input  logic                       room,
    output bws_pkg::mem_req_t          mem_req,
    output bws_pkg::read_tag_t         tag
);
    import bws_pkg::*;

    ctrl_state_t          state_reg, state_next;
    logic [COL_W-1:0]     view_reg, view_next;
    logic [WALK_W-1:0]    col_reg, col_next;
    logic [DOT_CNT_W-1:0] dot_cnt_reg, dot_cnt_next;
    logic [ADDR_W-1:0]    row_base_reg, row_base_next;
    logic                 blank_reg, blank_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;

    req_kind_t            kind;
    logic                 accept;
    logic                 issue;
    logic                 dot_last;
    logic                 clr_done;
    logic                 col_over;
    logic [WALK_W:0]      col_inc;
    logic [WALK_W-1:0]    col_step;
    logic [COL_W-1:0]     view_sum;
    logic [ROW_W-1:0]     phys_row;
    logic                 wr_ok;
    logic [ADDR_W-1:0]    wr_addr;
    logic                 scan_blank;

    assign kind     = req_kind_t'(req_type);
    assign accept   = in_valid && in_ready;
    assign issue    = (state_reg == ST_SCAN) && room;
    assign dot_last = (dot_cnt_reg == DOT_CNT_W'(SCREEN_COLS - 1));
    assign clr_done = (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1));

    // Column walk: reduce the start column into the row, then step with wrap.
    assign col_over = (32'(col_reg) >= BUFFER_COLS);
    assign col_inc  = {1'b0, col_reg} + (WALK_W + 1)'(1);
    assign col_step = (32'(col_inc) == BUFFER_COLS) ? '0 : col_inc[WALK_W-1:0];

    // Scroll tick wraps in nine bits and then against the limit.
    assign view_sum = view_reg + COL_W'(1);

    // Pixel write target: logical rows 0 and 1 swap with physical rows 2 and 3.
    assign phys_row = pixel_row ^ ROW_W'(2);
    assign wr_ok    = (32'(pixel_col) < BUFFER_COLS) && (32'(phys_row) < SCREEN_ROWS);
    assign wr_addr  = ADDR_W'(phys_row) * ADDR_W'(BUFFER_COLS) + ADDR_W'(pixel_col);

    assign scan_blank = (32'(pixel_row) >= SCREEN_ROWS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (kind == REQ_SCAN))
                begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                if (!col_over)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue && dot_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs: handshake, memory accesses and the read tag.
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        mem_req.we    = 1'b0;
        mem_req.waddr = wr_addr;
        mem_req.wdata = pixel_on;
        mem_req.re    = issue;
        mem_req.raddr = row_base_reg + ADDR_W'(col_reg);
        tag.issue     = issue;
        tag.blank     = blank_reg;
        tag.last      = dot_last;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_addr_reg;
                mem_req.wdata = 1'b0;
            end
            ST_IDLE:
            begin
                mem_req.we = accept && (kind == REQ_WRITE) && wr_ok;
            end
            default:
            begin
                mem_req.we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        view_next     = view_reg;
        col_next      = col_reg;
        dot_cnt_next  = dot_cnt_reg;
        row_base_next = row_base_reg;
        blank_next    = blank_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        REQ_SCAN:
                        begin
                            col_next      = WALK_W'(view_reg);
                            dot_cnt_next  = '0;
                            blank_next    = scan_blank;
                            row_base_next = scan_blank ? '0
                                : ADDR_W'(pixel_row) * ADDR_W'(BUFFER_COLS);
                        end
                        REQ_VIEW:
                        begin
                            if (32'(view_start) < BUFFER_COLS)
                            begin
                                view_next = view_start;
                            end
                        end
                        REQ_SCROLL:
                        begin
                            view_next = (view_sum >= scroll_limit) ? '0 : view_sum;
                        end
                        default:
                        begin
                            view_next = view_reg;
                        end
                    endcase
                end
            end
            ST_WRAP:
            begin
                if (col_over)
                begin
                    col_next = col_reg - WALK_W'(BUFFER_COLS);
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    col_next     = col_step;
                    dot_cnt_next = dot_cnt_reg + DOT_CNT_W'(1);
                end
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            view_reg     <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            view_reg     <= view_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Scan walk registers.
    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        dot_cnt_reg  <= dot_cnt_next;
        row_base_reg <= row_base_next;
        blank_reg    <= blank_next;
    end

endmodule

/* design/bws_out_queue.sv */
// Two-entry dot queue that catches memory read data and holds it for the output side.
// Depends on bws_pkg for the read tag struct.
module bws_out_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  bws_pkg::read_tag_t tag,
    input  logic               rdata,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               dot,
    output logic               last_dot
);
    import bws_pkg::*;

    read_tag_t  tag_reg;
    logic [1:0] dot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;
    logic [2:0] occ_next;

    assign push      = tag_reg.issue;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign dot       = dot_reg[rd_ptr_reg][1];
    assign last_dot  = dot_reg[rd_ptr_reg][0];

    // A read may start only if its data will find a free slot when it arrives.
    assign occ_next = {1'b0, count_reg} + {2'b00, push} - {2'b00, pop};
    assign room     = (occ_next <= 3'd1);

    // Tag is registered to line up with the registered memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= occ_next[1:0];
        end
    end

    // Queue storage: the dot is forced low for a row outside the store.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            dot_reg[wr_ptr_reg] <= {rdata && !tag_reg.blank, tag_reg.last};
        end
    end

endmodule

/* design/bitmap_window_scanout.sv */
// Top level of the scrolling bitmap window scanout: sequencer, pixel RAM, dot queue.
// Depends on bws_pkg, bws_ctrl, bws_bitmap_ram and bws_out_queue.
//
//   channel | signals                                                  | direction
//   --------+----------------------------------------------------------+----------
//   in      | in_valid, in_ready, req_type, pixel_col, pixel_row,      | request in
//           | pixel_on, view_start, scroll_limit                       |
//   out     | out_valid, out_ready, dot, last_dot                      | dot out
//
// Write, set-view and scroll requests complete in their accept cycle.
// A scan request runs through the accept cycle, a state that reduces the start
// column into the row, then one dot per cycle through the bitmap RAM read port
// while the dot queue has room. A view offset at or above BUFFER_COLS takes one
// more reduction step.
// After reset a clearing pass writes zero to all STORE_DEPTH (1280) pixels, one
// per cycle, with in_ready low.
// A stalled output side holds off RAM reads through a two-entry dot queue.
module bitmap_window_scanout (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bws_pkg::KIND_W-1:0] req_type,
    input  logic [bws_pkg::COL_W-1:0]  pixel_col,
    input  logic [bws_pkg::ROW_W-1:0]  pixel_row,
    input  logic                       pixel_on,
    input  logic [bws_pkg::COL_W-1:0]  view_start,
    input  logic [bws_pkg::COL_W-1:0]  scroll_limit,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       dot,
    output logic                       last_dot
);
    import bws_pkg::*;

    mem_req_t  mem_req;
    read_tag_t tag;
    logic      rdata;
    logic      room;

    // Request sequencer.
    bws_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .pixel_col    (pixel_col),
        .pixel_row    (pixel_row),
        .pixel_on     (pixel_on),
        .view_start   (view_start),
        .scroll_limit (scroll_limit),
        .room         (room),
        .mem_req      (mem_req),
        .tag          (tag)
    );

    // Pixel store.
    bws_bitmap_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    // Output dot queue.
    bws_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .rdata     (rdata),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dot       (dot),
        .last_dot  (last_dot)
    );

endmodule

/* design/bws_checker.sv */
// Port-level checks for the scrolling bitmap window scanout, bound to the top level.
// Depends on bws_pkg for the window width.
module bws_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic [bws_pkg::KIND_W-1:0] req_type,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       dot,
    input logic                       last_dot
);
    import bws_pkg::*;

    logic [DOT_CNT_W-1:0] seen_reg;
    logic [2:0]           pend_reg;
    logic                 scan_in;
    logic                 dot_out;
    logic                 row_end;

    assign scan_in = in_valid && in_ready && (req_type == REQ_SCAN);
    assign dot_out = out_valid && out_ready;
    assign row_end = dot_out && last_dot;

    // Dots delivered in the current row and scans not yet fully delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            pend_reg <= 3'd0;
        end
        else
        begin
            if (dot_out)
            begin
                seen_reg <= last_dot ? '0 : seen_reg + DOT_CNT_W'(1);
            end
            pend_reg <= pend_reg + {2'b00, scan_in} - {2'b00, row_end};
        end
    end

    // A stalled dot holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dot) && $stable(last_dot))
        else $error("dot changed while stalled");

    // The row end falls on exactly the last dot of the window.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        dot_out |-> (last_dot == (seen_reg == DOT_CNT_W'(SCREEN_COLS - 1))))
        else $error("last_dot out of place");

    // Dots appear only for an accepted scan.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 3'd0))
        else $error("dot without a scan request");

    // At most two scans are ever open, one draining and one issuing.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_in |-> (pend_reg <= 3'd1))
        else $error("too many open scans");

endmodule

bind bitmap_window_scanout bws_checker u_bws_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dot       (dot),
    .last_dot  (last_dot)
);
